// ===== sv/q8_block_quantizer_top_macros.svh =====
// Assertion macros for the q8 block quantizer.
// Included by q8_block_quantizer_top; expects clk and rst_n in the including scope.
`ifndef Q8_BLOCK_QUANTIZER_TOP_MACROS_SVH
`define Q8_BLOCK_QUANTIZER_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define Q8BQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define Q8BQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/q8bq_pkg.sv =====
// Shared constants for the q8 block quantizer.
// No dependencies; used by the output channel interface and the top level.
package q8bq_pkg;

  localparam int CODE_W      = 8;    // signed code width
  localparam int SLOT_W      = 5;    // slot field width
  localparam int SCALE_W     = 32;   // Q8.24 scale width
  localparam int QMAX        = 127;  // largest code magnitude
  localparam int SCALE_DIV   = 254;  // 2 * QMAX, divisor of the scale
  localparam int SCALE_SHIFT = 9;    // Q16 -> Q24, plus one bit for rounding
  localparam int SCALE_QBITS = 34;   // scale quotient bits incl. two overflow bits
  localparam int CODE_QBITS  = 7;    // code quotient bits
  localparam int STEP_W      = 6;    // divider step counter width

endpackage

// ===== sv/q8bq_if.sv =====
// Valid/ready channel interfaces for the q8 block quantizer.
// Depends on q8bq_pkg for the result field widths.
interface q8bq_in_if #(
  parameter int SAMPLE_WIDTH = 32
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic                           tensor_end;

  modport source (output valid, output sample, output tensor_end, input ready);
  modport sink   (input valid, input sample, input tensor_end, output ready);
endinterface

interface q8bq_out_if
  import q8bq_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic signed [CODE_W-1:0] code;
  logic [SLOT_W-1:0]        slot;
  logic [SCALE_W-1:0]       block_scale;
  logic                     block_done;

  modport source (output valid, output code, output slot, output block_scale,
                  output block_done, input ready);
  modport sink   (input valid, input code, input slot, input block_scale,
                  input block_done, output ready);
endinterface

// ===== sv/q8_block_quantizer_top.sv =====
// Operation: samples are accepted while the block fills. At block close the scale is
//   divided out, then each code is read, loaded, divided and output, waiting as long as
//   out_ch.ready is low. The single shared restoring divider serves the scale and every
//   code; no new samples are accepted until the last code of the block transfers.
// Reset: synchronous, active low; clears state, fill count, absmax and emit index.
//   The sample store is not cleared; only entries of the current block are read.
`include "q8_block_quantizer_top_macros.svh"

module q8_block_quantizer_top
  import q8bq_pkg::*;
#(
  parameter int BLOCK_SIZE   = 32,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  q8bq_in_if.sink      in_ch,
  q8bq_out_if.source   out_ch
);

  localparam int AW = $clog2(BLOCK_SIZE);
  localparam int CW = $clog2(BLOCK_SIZE + 1);
  // Divider datapath: wide enough for the scale numerator and 254 << 33.
  localparam int RW = (SAMPLE_WIDTH + 9 > 42) ? SAMPLE_WIDTH + 9 : 42;

  typedef enum logic [5:0] {
    S_FILL  = 6'b000001,  // accept samples, track absmax
    S_SCALE = 6'b000010,  // divide for the block scale
    S_READ  = 6'b000100,  // read one stored sample
    S_LOAD  = 6'b001000,  // set up the code division
    S_DIV   = 6'b010000,  // divide for the code
    S_OUT   = 6'b100000   // hold the result until it transfers
  } state_t;

  state_t                   state_r, state_nxt;
  logic [CW-1:0]            fill_r, fill_nxt;
  logic [CW-1:0]            emit_r, emit_nxt;
  logic [SAMPLE_WIDTH-1:0]  absmax_r, absmax_nxt;
  logic [RW-1:0]            rem_r, rem_nxt;
  logic [RW-1:0]            dsh_r, dsh_nxt;
  logic [SCALE_QBITS-1:0]   quo_r, quo_nxt;
  logic [STEP_W-1:0]        step_r, step_nxt;
  logic                     neg_r, neg_nxt;
  logic [SCALE_W-1:0]       scale_r, scale_nxt;
  logic signed [CODE_W-1:0] code_r, code_nxt;

  logic [SAMPLE_WIDTH-1:0]  store_mem [BLOCK_SIZE];
  logic [SAMPLE_WIDTH-1:0]  rd_data_r;

  logic                     in_xfer;
  logic                     out_xfer;
  logic                     last_emit;
  logic [SAMPLE_WIDTH-1:0]  in_mag;
  logic [SAMPLE_WIDTH-1:0]  rd_mag;
  logic [SAMPLE_WIDTH-1:0]  amax_new;

  // Shared divider step: compare, conditional subtract, shift in quotient bit.
  logic                     div_ge;
  logic [RW-1:0]            div_rem;
  logic [SCALE_QBITS-1:0]   div_quo;
  logic [CODE_W-1:0]        code_mag;

  assign in_xfer   = in_ch.valid && in_ch.ready;
  assign out_xfer  = out_ch.valid && out_ch.ready;
  assign last_emit = ((emit_r + CW'(1)) == fill_r);

  assign in_mag   = in_ch.sample[SAMPLE_WIDTH-1] ?
                    SAMPLE_WIDTH'(~in_ch.sample + SAMPLE_WIDTH'(1)) :
                    SAMPLE_WIDTH'(in_ch.sample);
  assign rd_mag   = rd_data_r[SAMPLE_WIDTH-1] ?
                    SAMPLE_WIDTH'(~rd_data_r + SAMPLE_WIDTH'(1)) : rd_data_r;
  assign amax_new = (in_mag > absmax_r) ? in_mag : absmax_r;

  assign div_ge   = (rem_r >= dsh_r);
  assign div_rem  = div_ge ? (rem_r - dsh_r) : rem_r;
  assign div_quo  = {quo_r[SCALE_QBITS-2:0], div_ge};
  // All-zero block: force the code to zero instead of dividing by zero.
  assign code_mag = (absmax_r == '0) ? '0 : {1'b0, div_quo[CODE_QBITS-1:0]};

  always_comb begin
    state_nxt  = state_r;
    fill_nxt   = fill_r;
    emit_nxt   = emit_r;
    absmax_nxt = absmax_r;
    rem_nxt    = rem_r;
    dsh_nxt    = dsh_r;
    quo_nxt    = quo_r;
    step_nxt   = step_r;
    neg_nxt    = neg_r;
    scale_nxt  = scale_r;
    code_nxt   = code_r;
    case (state_r)
      S_FILL: begin
        if (in_xfer) begin
          fill_nxt   = fill_r + CW'(1);
          absmax_nxt = amax_new;
          // Close the block when full or at the tensor end; start the scale divide.
          if (in_ch.tensor_end || (fill_r == CW'(BLOCK_SIZE - 1))) begin
            rem_nxt   = (RW'(amax_new) << SCALE_SHIFT) + RW'(QMAX);
            dsh_nxt   = RW'(SCALE_DIV) << (SCALE_QBITS - 1);
            quo_nxt   = '0;
            step_nxt  = STEP_W'(SCALE_QBITS - 1);
            state_nxt = S_SCALE;
          end
        end
      end
      S_SCALE: begin
        rem_nxt  = div_rem;
        dsh_nxt  = dsh_r >> 1;
        quo_nxt  = div_quo;
        step_nxt = step_r - STEP_W'(1);
        if (step_r == '0) begin
          // Saturate when the quotient spills past 32 bits.
          scale_nxt = (div_quo[SCALE_QBITS-1:SCALE_W] != '0) ? '1 : div_quo[SCALE_W-1:0];
          emit_nxt  = '0;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        // Numerator 254*mag + absmax, divisor 2*absmax aligned to the top quotient bit.
        rem_nxt   = (RW'(rd_mag) << 8) - (RW'(rd_mag) << 1) + RW'(absmax_r);
        dsh_nxt   = RW'(absmax_r) << CODE_QBITS;
        quo_nxt   = '0;
        step_nxt  = STEP_W'(CODE_QBITS - 1);
        neg_nxt   = rd_data_r[SAMPLE_WIDTH-1];
        state_nxt = S_DIV;
      end
      S_DIV: begin
        rem_nxt  = div_rem;
        dsh_nxt  = dsh_r >> 1;
        quo_nxt  = div_quo;
        step_nxt = step_r - STEP_W'(1);
        if (step_r == '0) begin
          code_nxt  = neg_r ? CODE_W'(-code_mag) : code_mag;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_xfer) begin
          if (last_emit) begin
            fill_nxt   = '0;
            absmax_nxt = '0;
            emit_nxt   = '0;
            state_nxt  = S_FILL;
          end else begin
            emit_nxt  = emit_r + CW'(1);
            state_nxt = S_READ;
          end
        end
      end
      default: begin
        state_nxt = S_FILL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_FILL;
      fill_r   <= '0;
      emit_r   <= '0;
      absmax_r <= '0;
    end else begin
      state_r  <= state_nxt;
      fill_r   <= fill_nxt;
      emit_r   <= emit_nxt;
      absmax_r <= absmax_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r   <= rem_nxt;
    dsh_r   <= dsh_nxt;
    quo_r   <= quo_nxt;
    step_r  <= step_nxt;
    neg_r   <= neg_nxt;
    scale_r <= scale_nxt;
    code_r  <= code_nxt;
  end

  // Sample store: write on input transfer, registered read at the emit index.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      store_mem[fill_r[AW-1:0]] <= in_ch.sample;
    end
    rd_data_r <= store_mem[emit_r[AW-1:0]];
  end

  assign in_ch.ready        = (state_r == S_FILL);
  assign out_ch.valid       = (state_r == S_OUT);
  assign out_ch.code        = code_r;
  assign out_ch.slot        = SLOT_W'(emit_r);
  assign out_ch.block_scale = scale_r;
  assign out_ch.block_done  = last_emit;

  `Q8BQ_ASSERT_NOW(a_no_overlap, in_ch.ready, !out_ch.valid, "ready while a result is pending")
  `Q8BQ_ASSERT_NOW(a_fill_bound, state_r == S_FILL, fill_r < CW'(BLOCK_SIZE), "fill overran")
  `Q8BQ_ASSERT_NOW(a_emit_bound, out_ch.valid, emit_r < fill_r, "emit index past fill")
  `Q8BQ_ASSERT_NOW(a_code_range, out_ch.valid, out_ch.code != CODE_W'(-128), "code out of range")
  `Q8BQ_ASSERT_NEXT(a_block_reset, out_xfer && out_ch.block_done,
                    (state_r == S_FILL) && (fill_r == '0) && (absmax_r == '0),
                    "block state not cleared after last code")

endmodule
